[hw/rtl/spq_pkg.sv]
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, codes and the types shared by the queue cells and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned VALUE_WIDTH    = 32;
  localparam int unsigned PRIORITY_WIDTH = 8;
  localparam int unsigned COUNT_WIDTH    = $clog2(DEPTH + 1);
  localparam int unsigned STATUS_WIDTH   = 2;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_DEQ_EMPTY = 2'd1,
    STATUS_ENQ_FULL  = 2'd2
  } status_e;

  // Contents of one queue cell.
  typedef struct packed {
    logic                      valid;
    logic [VALUE_WIDTH-1:0]    value;
    logic [PRIORITY_WIDTH-1:0] prio;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                      enq;
    logic                      deq;
    logic [VALUE_WIDTH-1:0]    value;
    logic [PRIORITY_WIDTH-1:0] prio;
  } ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on an insert it keeps, takes the new entry or takes its
// front neighbor, and on a removal it takes its back neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire spq_pkg::ctrl_t  ctrl_i,
  input  wire spq_pkg::entry_t prev_entry_i,
  input  wire logic            prev_behind_i,
  input  wire spq_pkg::entry_t next_entry_i,
  output spq_pkg::entry_t      entry_o,
  output logic                 behind_o
);

  logic                               valid_q, valid_d;
  logic [spq_pkg::VALUE_WIDTH-1:0]    value_q, value_d;
  logic [spq_pkg::PRIORITY_WIDTH-1:0] prio_q, prio_d;

  // The new entry belongs behind this one when this one is held and its
  // priority does not exceed the new one, which keeps equal priorities FIFO.
  assign behind_o = valid_q && (prio_q <= ctrl_i.prio);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.enq) begin
      if (behind_o) begin
        valid_d = valid_q;
      end else if (prev_behind_i) begin
        valid_d = 1'b1;
        value_d = ctrl_i.value;
        prio_d  = ctrl_i.prio;
      end else begin
        valid_d = prev_entry_i.valid;
        value_d = prev_entry_i.value;
        prio_d  = prev_entry_i.prio;
      end
    end else if (ctrl_i.deq) begin
      valid_d = next_entry_i.valid;
      value_d = next_entry_i.value;
      prio_d  = next_entry_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign entry_o = '{valid: valid_q, value: value_q, prio: prio_q};

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// ---------------------------------------------------------------------------
// Sorted priority queue, smallest priority first
// A chain of cells keeps the entries sorted; each transaction inserts or removes
// at most one entry and returns one result describing the queue afterwards.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o   op, item_value, item_priority
//   out      output     out_valid_o/out_stall_i status, front_value,
//                                              front_priority, empty_res,
//                                              full_res, entry_count
//
// An input transaction is applied to every cell at once in the cycle it is
// accepted; its result appears on the out channel in the next cycle.
// One transaction can be accepted every cycle unless a held result is stalled,
// set by the single compare-and-shift step that all cells take in parallel.
// The input stalls only while a result is held and the output is stalled.
// Reset clears the cell valid bits, the count, the status and the output valid only.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [0:0]                         op_i,
  input  wire logic [spq_pkg::VALUE_WIDTH-1:0]    item_value_i,
  input  wire logic [spq_pkg::PRIORITY_WIDTH-1:0] item_priority_i,
  // Output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [spq_pkg::STATUS_WIDTH-1:0]        status_o,
  output logic [spq_pkg::VALUE_WIDTH-1:0]         front_value_o,
  output logic [spq_pkg::PRIORITY_WIDTH-1:0]      front_priority_o,
  output logic                                    empty_res_o,
  output logic                                    full_res_o,
  output logic [spq_pkg::COUNT_WIDTH-1:0]         entry_count_o
);

  localparam logic [spq_pkg::COUNT_WIDTH-1:0] CountFull =
    spq_pkg::COUNT_WIDTH'(spq_pkg::DEPTH);
  localparam logic [spq_pkg::COUNT_WIDTH-1:0] CountOne =
    spq_pkg::COUNT_WIDTH'(1);

  // Handshake and queue occupancy.
  logic                              in_accept;
  logic                              is_deq;
  logic                              q_empty;
  logic                              q_full;
  logic                              out_valid_q, out_valid_d;
  spq_pkg::status_e                  status_q, status_d;
  logic [spq_pkg::COUNT_WIDTH-1:0]   count_q, count_d;
  spq_pkg::ctrl_t                    ctrl;

  // Cell chain.
  spq_pkg::entry_t                   entries  [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0]         behind;
  logic [spq_pkg::DEPTH-1:0]         valid_vec;
  spq_pkg::entry_t                   head_entry;
  spq_pkg::entry_t                   tail_entry;

  // A held result blocks new transactions only while it cannot leave.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_deq     = (op_i == spq_pkg::OP_DEQ);
  assign q_empty    = (count_q == '0);
  assign q_full     = (count_q == CountFull);

  // Dropped inserts and removals from an empty queue leave the cells alone.
  always_comb begin
    ctrl.enq   = in_accept && !is_deq && !q_full;
    ctrl.deq   = in_accept && is_deq && !q_empty;
    ctrl.value = item_value_i;
    ctrl.prio  = item_priority_i;
  end

  always_comb begin
    count_d     = count_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_accept) begin
      out_valid_d = 1'b1;
      if (is_deq) begin
        if (q_empty) begin
          status_d = spq_pkg::STATUS_DEQ_EMPTY;
        end else begin
          status_d = spq_pkg::STATUS_DONE;
          count_d  = count_q - CountOne;
        end
      end else begin
        if (q_full) begin
          status_d = spq_pkg::STATUS_ENQ_FULL;
        end else begin
          status_d = spq_pkg::STATUS_DONE;
          count_d  = count_q + CountOne;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= spq_pkg::STATUS_DONE;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      count_q     <= count_d;
    end
  end

  // The front cell sees a held sentinel ahead of it, so an insert that is
  // not behind the front entry lands there. The last cell pulls in an empty
  // entry on a removal.
  assign head_entry = '{valid: 1'b1, value: '0, prio: '0};
  assign tail_entry = '{valid: 1'b0, value: '0, prio: '0};

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::entry_t prev_entry;
    spq_pkg::entry_t next_entry;
    logic            prev_behind;

    if (i == 0) begin : g_head
      assign prev_entry  = head_entry;
      assign prev_behind = 1'b1;
    end else begin : g_mid
      assign prev_entry  = entries[i-1];
      assign prev_behind = behind[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign next_entry = tail_entry;
    end else begin : g_body
      assign next_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .prev_entry_i  (prev_entry),
      .prev_behind_i (prev_behind),
      .next_entry_i  (next_entry),
      .entry_o       (entries[i]),
      .behind_o      (behind[i])
    );

    assign valid_vec[i] = entries[i].valid;
  end

  // The cells already hold the state after the step while the result waits,
  // since nothing is accepted until the result leaves.
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign front_value_o    = q_empty ? '0 : entries[0].value;
  assign front_priority_o = q_empty ? '0 : entries[0].prio;
  assign empty_res_o      = q_empty;
  assign full_res_o       = q_full;
  assign entry_count_o    = count_q;

  // The count register must track the number of held cells.
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("entry count differs from held cells");

  // Held cells always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + spq_pkg::DEPTH'(1)) & valid_vec) == '0)
    else $error("held cells are not contiguous from the front");

  // A removal from an empty queue is reported as such.
  a_deq_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_deq && q_empty) |=>
      (status_q == spq_pkg::STATUS_DEQ_EMPTY) && (count_q == '0))
    else $error("removal on empty queue misreported");

  // An insert into a full queue is dropped and leaves the queue full.
  a_enq_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !is_deq && q_full) |=>
      (status_q == spq_pkg::STATUS_ENQ_FULL) && $stable(valid_vec))
    else $error("insert on full queue changed the queue");

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives enqueue and dequeue transactions and checks every result against a
// shadow queue kept in the bench or a typed table row. It covers a directed
// table first, then random bursts under varying idle and stall patterns.
// ---------------------------------------------------------------------------

module tb;

  // One result as the block reports it after a transaction.
  typedef struct packed {
    spq_pkg::status_e                   status;
    logic [spq_pkg::VALUE_WIDTH-1:0]    front_value;
    logic [spq_pkg::PRIORITY_WIDTH-1:0] front_prio;
    logic                               empty;
    logic                               full;
    logic [spq_pkg::COUNT_WIDTH-1:0]    count;
  } queue_report_t;

  // One row of the directed table. A row is sent reps times. With scramble
  // set, the value and priority are drawn at random for each repetition.
  // With typed set, the written-out result is expected instead of the
  // shadow queue's own prediction.
  typedef struct packed {
    spq_pkg::op_e                       op;
    logic [spq_pkg::VALUE_WIDTH-1:0]    value;
    logic [spq_pkg::PRIORITY_WIDTH-1:0] prio;
    logic [7:0]                         reps;
    logic                               scramble;
    logic                               typed;
    queue_report_t                      want;
  } stim_row_t;

  localparam queue_report_t UNTYPED =
    '{spq_pkg::STATUS_DONE, '0, '0, 1'b0, 1'b0, '0};

  // Clock, reset and the input side of both channels. Every input of the
  // block holds a known value from time zero.
  logic                               clk_i           = 1'b0;
  logic                               rst_ni          = 1'b0;
  logic                               in_valid_i      = 1'b0;
  logic [0:0]                         op_i            = spq_pkg::OP_ENQ;
  logic [spq_pkg::VALUE_WIDTH-1:0]    item_value_i    = '0;
  logic [spq_pkg::PRIORITY_WIDTH-1:0] item_priority_i = '0;
  logic                               out_stall_i     = 1'b0;

  logic                               in_stall_o;
  logic                               out_valid_o;
  logic [spq_pkg::STATUS_WIDTH-1:0]   status_o;
  logic [spq_pkg::VALUE_WIDTH-1:0]    front_value_o;
  logic [spq_pkg::PRIORITY_WIDTH-1:0] front_priority_o;
  logic                               empty_res_o;
  logic                               full_res_o;
  logic [spq_pkg::COUNT_WIDTH-1:0]    entry_count_o;

  sorted_priority_queue dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .item_value_i     (item_value_i),
    .item_priority_i  (item_priority_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .front_value_o    (front_value_o),
    .front_priority_o (front_priority_o),
    .empty_res_o      (empty_res_o),
    .full_res_o       (full_res_o),
    .entry_count_o    (entry_count_o)
  );

  // 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the queue. Slots 0..shadow_count-1 hold the entries in
  // the order they leave, so slot 0 is always the front.
  logic [spq_pkg::VALUE_WIDTH-1:0]    shadow_value [spq_pkg::DEPTH];
  logic [spq_pkg::PRIORITY_WIDTH-1:0] shadow_prio  [spq_pkg::DEPTH];
  int                                 shadow_count = 0;

  // Results that accepted transactions still owe, oldest first.
  queue_report_t reports_due [$];

  int mismatch_count = 0;

  // Knobs set by the stimulus process and read by the drivers. Percentages
  // give the chance of an idle or stall cycle.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Raised by the stimulus process to ask the receiver for one long hold-off.
  // The receiver takes the request, clears it and counts the stretch itself.
  bit hold_req       = 1'b0;
  int hold_left      = 0;

  // Applies one transaction to the shadow queue and returns the result the
  // block has to report for it. A new entry goes behind every entry whose
  // priority is less than or equal to its own, which keeps equal priorities
  // in arrival order. A full queue drops the entry; an empty queue refuses a
  // dequeue. In both cases the queue is left alone and only the status
  // tells.
  function automatic queue_report_t step_shadow_queue(
      input spq_pkg::op_e                       op,
      input logic [spq_pkg::VALUE_WIDTH-1:0]    value,
      input logic [spq_pkg::PRIORITY_WIDTH-1:0] prio);
    queue_report_t rep;
    int            slot;
    int            i;
    rep.status = spq_pkg::STATUS_DONE;
    if (op == spq_pkg::OP_ENQ) begin
      if (shadow_count == spq_pkg::DEPTH) begin
        rep.status = spq_pkg::STATUS_ENQ_FULL;
      end else begin
        slot = 0;
        while (slot < shadow_count && shadow_prio[slot] <= prio) slot++;
        for (i = shadow_count; i > slot; i--) begin
          shadow_value[i] = shadow_value[i-1];
          shadow_prio[i]  = shadow_prio[i-1];
        end
        shadow_value[slot] = value;
        shadow_prio[slot]  = prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      rep.status = spq_pkg::STATUS_DEQ_EMPTY;
    end else begin
      for (i = 0; i < shadow_count - 1; i++) begin
        shadow_value[i] = shadow_value[i+1];
        shadow_prio[i]  = shadow_prio[i+1];
      end
      shadow_count--;
    end
    // An empty queue reports a zero front.
    rep.front_value = (shadow_count != 0) ? shadow_value[0] : '0;
    rep.front_prio  = (shadow_count != 0) ? shadow_prio[0] : '0;
    rep.empty       = (shadow_count == 0);
    rep.full        = (shadow_count == spq_pkg::DEPTH);
    rep.count       = spq_pkg::COUNT_WIDTH'(shadow_count);
    return rep;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Compares the result on the output port with the oldest one owed.
  task automatic check_report();
    queue_report_t want;
    if (reports_due.size() == 0) begin
      report_mismatch("result arrived with no transaction outstanding");
      return;
    end
    want = reports_due.pop_front();
    check_field("status", 64'(status_o), 64'(want.status));
    check_field("front_value", 64'(front_value_o), 64'(want.front_value));
    check_field("front_priority", 64'(front_priority_o), 64'(want.front_prio));
    check_field("empty_res", 64'(empty_res_o), 64'(want.empty));
    check_field("full_res", 64'(full_res_o), 64'(want.full));
    check_field("entry_count", 64'(entry_count_o), 64'(want.count));
  endtask

  // Offers one transaction, after a random number of idle cycles, and waits
  // until it is accepted. It is entered and left just after a rising edge,
  // so every drive below is the only one in its time step. Outputs of the
  // block are read before any of its own updates at that edge land.
  task automatic offer_item(input spq_pkg::op_e                       op,
                            input logic [spq_pkg::VALUE_WIDTH-1:0]    value,
                            input logic [spq_pkg::PRIORITY_WIDTH-1:0] prio,
                            input logic                               typed,
                            input queue_report_t                      want);
    queue_report_t due;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    item_value_i    <= value;
    item_priority_i <= prio;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // Accepted at this edge. The shadow queue always advances, even when the
    // table supplies the result to expect.
    due = step_shadow_queue(op, value, prio);
    reports_due.push_back(typed ? want : due);
  endtask

  // Sends random transactions in bursts. Each burst leans toward enqueues,
  // toward dequeues or toward neither, so the queue keeps running into both
  // the full and the empty state. Priorities often come from a tiny range to
  // give many ties, and values hit both extremes now and then.
  task automatic offer_random_items(input int total);
    int                                 sent;
    int                                 burst;
    int                                 enq_pct;
    spq_pkg::op_e                       op;
    logic [spq_pkg::VALUE_WIDTH-1:0]    value;
    logic [spq_pkg::PRIORITY_WIDTH-1:0] prio;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(60, 10);
      case ($urandom_range(2))
        0: enq_pct = 20;
        1: enq_pct = 50;
        default: enq_pct = 80;
      endcase
      repeat (burst) begin
        op = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
        case ($urandom_range(9))
          0: value = '0;
          1: value = '1;
          default: value = spq_pkg::VALUE_WIDTH'($urandom);
        endcase
        case ($urandom_range(3))
          0: prio = spq_pkg::PRIORITY_WIDTH'($urandom_range(3));
          1: prio = '1 - spq_pkg::PRIORITY_WIDTH'($urandom_range(1));
          default: prio = spq_pkg::PRIORITY_WIDTH'($urandom);
        endcase
        offer_item(op, value, prio, 1'b0, UNTYPED);
        sent++;
      end
    end
  endtask

  // Holds the input idle until every owed result has come back. It always waits
  // for a rising edge before it checks, so the idle drive never shares a time
  // step with the next offer.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (reports_due.size() != 0);
  endtask

  // Directed table. It starts from reset, hits both extremes of value and
  // priority, checks that ties leave in arrival order, fills the queue to
  // the top, tries an enqueue on the full queue, drains it completely and
  // tries a dequeue on the empty queue. Dequeues carry junk operands, which
  // the block has to ignore.
  stim_row_t directed_rows [12] = '{
    '{spq_pkg::OP_DEQ, 32'hFFFF_FFFF, 8'hFF, 8'd1, 1'b0, 1'b1,
      '{spq_pkg::STATUS_DEQ_EMPTY, 32'h0, 8'h0, 1'b1, 1'b0, 5'd0}},
    '{spq_pkg::OP_ENQ, 32'hFFFF_FFFF, 8'hFF, 8'd1, 1'b0, 1'b1,
      '{spq_pkg::STATUS_DONE, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 5'd1}},
    '{spq_pkg::OP_ENQ, 32'h0, 8'h00, 8'd1, 1'b0, 1'b1,
      '{spq_pkg::STATUS_DONE, 32'h0, 8'h00, 1'b0, 1'b0, 5'd2}},
    // Same priority as the front entry, so it has to queue up behind it.
    '{spq_pkg::OP_ENQ, 32'h5, 8'h00, 8'd1, 1'b0, 1'b1,
      '{spq_pkg::STATUS_DONE, 32'h0, 8'h00, 1'b0, 1'b0, 5'd3}},
    '{spq_pkg::OP_DEQ, 32'h3C3C_3C3C, 8'h01, 8'd1, 1'b0, 1'b1,
      '{spq_pkg::STATUS_DONE, 32'h5, 8'h00, 1'b0, 1'b0, 5'd2}},
    '{spq_pkg::OP_ENQ, 32'h1, 8'hFF, 8'd1, 1'b0, 1'b0, UNTYPED},
    // Fill up to the last free slot with random entries.
    '{spq_pkg::OP_ENQ, 32'h0, 8'h00, 8'd13, 1'b1, 1'b0, UNTYPED},
    // The queue is full now, so this entry is dropped.
    '{spq_pkg::OP_ENQ, 32'hDEAD_BEEF, 8'h00, 8'd1, 1'b0, 1'b0, UNTYPED},
    '{spq_pkg::OP_DEQ, 32'h0, 8'h00, 8'd16, 1'b1, 1'b0, UNTYPED},
    '{spq_pkg::OP_DEQ, 32'hFFFF_FFFF, 8'hFF, 8'd1, 1'b0, 1'b1,
      '{spq_pkg::STATUS_DEQ_EMPTY, 32'h0, 8'h0, 1'b1, 1'b0, 5'd0}},
    '{spq_pkg::OP_ENQ, 32'h1234_5678, 8'h7F, 8'd1, 1'b0, 1'b1,
      '{spq_pkg::STATUS_DONE, 32'h1234_5678, 8'h7F, 1'b0, 1'b0, 5'd1}},
    '{spq_pkg::OP_DEQ, 32'hA5A5_A5A5, 8'h5A, 8'd1, 1'b0, 1'b1,
      '{spq_pkg::STATUS_DONE, 32'h0, 8'h0, 1'b1, 1'b0, 5'd0}}
  };

  // Receiver. Each rising edge it checks an accepted result and then picks
  // the stall for the next cycle. A hold-off request from the stimulus
  // process turns into an unbroken run of stalled cycles, counted here.
  initial begin : drain_results
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_report();
      if (hold_req) begin
        hold_left = 64;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Stimulus and the end of the run.
  initial begin : stimulus
    stim_row_t row;
    int        k;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First idle pattern: the sender idles now and then, the receiver
    // stalls often. The directed table runs under it too.
    send_idle_pct  = 27;
    recv_stall_pct = 45;
    foreach (directed_rows[r]) begin
      for (k = 0; k < directed_rows[r].reps; k++) begin
        row = directed_rows[r];
        if (row.scramble) begin
          row.value = spq_pkg::VALUE_WIDTH'($urandom);
          row.prio  = spq_pkg::PRIORITY_WIDTH'($urandom_range(3)) << 6;
        end
        offer_item(row.op, row.value, row.prio, row.typed, row.want);
      end
    end
    offer_random_items(230);

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering every cycle, so the block has to stall its input.
    send_idle_pct = 0;
    hold_req      = 1'b1;
    offer_random_items(40);
    // The sender then goes quiet until every result is back.
    wait_until_drained();

    // Second idle pattern, the other way round.
    send_idle_pct  = 45;
    recv_stall_pct = 27;
    offer_random_items(250);
    wait_until_drained();

    // Last stretch at full rate with no idling on either side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    offer_random_items(250);

    // Let the outstanding results come home, then let the clock run on in case
    // the block sends anything it should not.
    in_valid_i <= 1'b0;
    for (k = 0; k < 5000 && reports_due.size() != 0; k++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (reports_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", reports_due.size()));

    if (mismatch_count == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #4_000_000;
    $display("[sorted_priority_queue] ERROR");
    $finish;
  end

endmodule
